/* hdl/assert_macros.svh */
// Assertion macros shared by the date offset RTL.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge out of reset.
`define CDO_ASSERT(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define CDO_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define CDO_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

/* hdl/cdo_pkg.sv */
// Package for the calendar date offset block: constants, types and calendar functions.
// No dependencies; used by cdo_day_unit and calendar_date_day_offset.
package cdo_pkg;

	localparam int CDO_OFFSET_BITS  = 17;
	localparam int CDO_YEAR_W       = 16;
	localparam int CDO_QUAD_DAYS    = 146097;
	localparam int CDO_YEAR_MAX     = 9999;
	localparam int CDO_REDUCE_STEPS = 6;
	localparam int CDO_LAST_MONTH   = 12;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_INIT,
		ST_YEAR,
		ST_MONTH
	} cdo_state_t;

	typedef enum logic [2:0] {
		OP_HOLD,
		OP_INIT,
		OP_ADD_QUAD,
		OP_SUB_QUAD,
		OP_ADD_YEAR,
		OP_SUB_YEAR,
		OP_SUB_MONTH
	} cdo_op_t;

	typedef enum logic [2:0] {
		YS_NONE,
		YS_INC,
		YS_DEC,
		YS_INC_QUAD,
		YS_DEC_QUAD
	} cdo_ystep_t;

	typedef enum logic [1:0] {
		FIN_NONE,
		FIN_DATE,
		FIN_LOW,
		FIN_HIGH
	} cdo_fin_t;

	// Command to the shared day adder.
	typedef struct packed {
		cdo_op_t     op;
		logic [8:0]  ylen;
		logic [4:0]  mlen;
		logic [9:0]  base;
	} cdo_cmd_t;

	// Leap rule from the year modulo 400.
	function automatic logic cdo_is_leap(input logic [8:0] r);
		return (r[1:0] == 2'd0) && (r != 9'd100) && (r != 9'd200) && (r != 9'd300);
	endfunction

	function automatic logic [4:0] cdo_month_len(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		unique case (m)
			4'd2:                     len = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			default:                  len = 5'd31;
		endcase
		return len;
	endfunction

	// Days in the months before month m of the same year.
	function automatic logic [8:0] cdo_days_before_month(input logic [3:0] m, input logic leap);
		logic [8:0] cum;
		unique case (m)
			4'd2:    cum = 9'd31;
			4'd3:    cum = 9'd59;
			4'd4:    cum = 9'd90;
			4'd5:    cum = 9'd120;
			4'd6:    cum = 9'd151;
			4'd7:    cum = 9'd181;
			4'd8:    cum = 9'd212;
			4'd9:    cum = 9'd243;
			4'd10:   cum = 9'd273;
			4'd11:   cum = 9'd304;
			4'd12:   cum = 9'd334;
			default: cum = 9'd0;
		endcase
		return cum + {8'd0, leap && (m > 4'd2)};
	endfunction

	// Restoring reduction modulo 400: multiples of 400 tried from the largest down.
	function automatic logic [13:0] cdo_reduce_amount(input logic [2:0] step);
		logic [13:0] amt;
		unique case (step)
			3'd0:    amt = 14'd12800;
			3'd1:    amt = 14'd6400;
			3'd2:    amt = 14'd3200;
			3'd3:    amt = 14'd1600;
			3'd4:    amt = 14'd800;
			default: amt = 14'd400;
		endcase
		return amt;
	endfunction

endpackage

/* hdl/calendar_date_day_offset.sv */
// Top level of the calendar date offset block: sequencer, year and month walk, result register.
// Depends on cdo_pkg, cdo_day_unit and assert_macros.svh.
//
//  channel   handshake            payload
//  request   start / busy         start_year, start_month, start_day, day_offset
//  result    done (one cycle)     result_year, result_month, result_day, out_of_range
//
// A request is taken at a rising edge with start high and busy low. Busy then stays high
// while the block reduces the start year modulo 400, forms the day count, takes 400-year
// steps and single-year steps, ends the year walk, takes month steps (at most 11) and loads
// the result. done follows in the next cycle; a clamped result leaves from the year walk
// and comes sooner. Each step is one add through the one day adder in cdo_day_unit.
// Reset clears the sequencer and the done strobe; the result fields are not reset.
// done is high for exactly one cycle, and the receiver cannot stall it.
`include "assert_macros.svh"

module calendar_date_day_offset
	import cdo_pkg::*;
#(
	parameter int OFFSET_BITS = CDO_OFFSET_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [13:0]            start_year,
	input  logic [3:0]             start_month,
	input  logic [4:0]             start_day,
	input  logic [OFFSET_BITS-1:0] day_offset,
	output logic                   done,
	output logic [13:0]            result_year,
	output logic [3:0]             result_month,
	output logic [4:0]             result_day,
	output logic                   out_of_range
);

	// The day count must hold the offset plus a year, and also plus or minus one 400-year cycle.
	localparam int DW = ((OFFSET_BITS > 18) ? OFFSET_BITS : 18) + 2;
	localparam logic signed [DW-1:0] QUAD_D = DW'(CDO_QUAD_DAYS);
	localparam logic signed [CDO_YEAR_W-1:0] YEAR_MAX_S = CDO_YEAR_W'(CDO_YEAR_MAX);
	localparam logic signed [CDO_YEAR_W-1:0] YEAR_ONE_S = CDO_YEAR_W'(1);
	localparam logic signed [CDO_YEAR_W-1:0] QUAD_YEARS = CDO_YEAR_W'(400);

	cdo_state_t state_q, state_nxt;

	// Working registers of the walk.
	logic signed [CDO_YEAR_W-1:0] year_q;
	logic [13:0]                  rem_q;      // year modulo 400 once the reduction ends
	logic [2:0]                   step_q;
	logic [3:0]                   month_q;
	logic [4:0]                   day_q;
	logic [OFFSET_BITS-1:0]       offset_q;
	logic signed [DW-1:0]         d_q;        // zero-based day within year_q, may run outside it

	logic                         done_q;

	// Controls from the sequencer.
	cdo_cmd_t   cmd;
	logic       d_load;
	cdo_ystep_t ystep;
	cdo_fin_t   fin;
	logic       red_en;
	logic       month_clear;
	logic       month_inc;

	logic signed [DW-1:0] d_sum;

	// Calendar facts about the current year.
	logic [8:0]  rem9;
	logic [8:0]  rem_inc;
	logic [8:0]  rem_dec;
	logic        leap_cur;
	logic        leap_prev;
	logic [8:0]  ylen_cur;
	logic [8:0]  ylen_prev;
	logic [4:0]  mlen_cur;
	logic [13:0] red_amt;
	logic [9:0]  init_base;

	logic accept;

	assign rem9      = rem_q[8:0];
	assign rem_inc   = (rem9 == 9'd399) ? 9'd0 : rem9 + 9'd1;
	assign rem_dec   = (rem9 == 9'd0) ? 9'd399 : rem9 - 9'd1;
	assign leap_cur  = cdo_is_leap(rem9);
	assign leap_prev = cdo_is_leap(rem_dec);
	assign ylen_cur  = 9'd365 + {8'd0, leap_cur};
	assign ylen_prev = 9'd365 + {8'd0, leap_prev};
	assign mlen_cur  = cdo_month_len(month_q, leap_cur);
	assign red_amt   = cdo_reduce_amount(step_q);

	// Days before the start month, plus the day of month, less one. Day zero in January gives minus one.
	assign init_base = {1'b0, cdo_days_before_month(month_q, leap_cur)} + {5'd0, day_q} - 10'd1;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;

	cdo_day_unit #(
		.OFFSET_BITS (OFFSET_BITS)
	) u_day_unit (
		.cmd    (cmd),
		.d_cur  (d_q),
		.offset (offset_q),
		.d_next (d_sum)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Sequencer. In the year phase a negative day count walks back and a count past the
	// year's length walks forward; whole 400-year cycles go in one step. The walk stops early
	// once the result year is known to lie outside 1..9999.
	always_comb begin
		state_nxt   = state_q;
		cmd.op      = OP_HOLD;
		cmd.ylen    = ylen_cur;
		cmd.mlen    = mlen_cur;
		cmd.base    = init_base;
		d_load      = 1'b0;
		ystep       = YS_NONE;
		fin         = FIN_NONE;
		red_en      = 1'b0;
		month_clear = 1'b0;
		month_inc   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_nxt = ST_REDUCE;
				end
			end
			ST_REDUCE: begin
				red_en = 1'b1;
				if (step_q == 3'(CDO_REDUCE_STEPS - 1)) begin
					state_nxt = ST_INIT;
				end
			end
			ST_INIT: begin
				cmd.op    = OP_INIT;
				d_load    = 1'b1;
				state_nxt = ST_YEAR;
			end
			ST_YEAR: begin
				if (d_q < 0) begin
					priority if (year_q <= YEAR_ONE_S) begin
						fin       = FIN_LOW;
						state_nxt = ST_IDLE;
					end else if (d_q <= -QUAD_D) begin
						cmd.op = OP_ADD_QUAD;
						d_load = 1'b1;
						ystep  = YS_DEC_QUAD;
					end else begin
						cmd.op   = OP_ADD_YEAR;
						cmd.ylen = ylen_prev;
						d_load   = 1'b1;
						ystep    = YS_DEC;
					end
				end else begin
					priority if (year_q > YEAR_MAX_S) begin
						fin       = FIN_HIGH;
						state_nxt = ST_IDLE;
					end else if (d_q >= QUAD_D) begin
						cmd.op = OP_SUB_QUAD;
						d_load = 1'b1;
						ystep  = YS_INC_QUAD;
					end else if (d_q >= $signed({{(DW-9){1'b0}}, ylen_cur})) begin
						cmd.op = OP_SUB_YEAR;
						d_load = 1'b1;
						ystep  = YS_INC;
					end else if (year_q < YEAR_ONE_S) begin
						fin       = FIN_LOW;
						state_nxt = ST_IDLE;
					end else begin
						month_clear = 1'b1;
						state_nxt   = ST_MONTH;
					end
				end
			end
			ST_MONTH: begin
				if ((month_q < 4'(CDO_LAST_MONTH)) &&
					(d_q >= $signed({{(DW-5){1'b0}}, mlen_cur}))) begin
					cmd.op    = OP_SUB_MONTH;
					d_load    = 1'b1;
					month_inc = 1'b1;
				end else begin
					fin       = FIN_DATE;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// Datapath registers of the walk.
	always_ff @(posedge clk) begin
		if (accept) begin
			year_q   <= {{(CDO_YEAR_W-14){1'b0}}, start_year};
			rem_q    <= start_year;
			step_q   <= 3'd0;
			// Month zero counts as January and months past twelve as December.
			if (start_month == 4'd0) begin
				month_q <= 4'd1;
			end else if (start_month > 4'(CDO_LAST_MONTH)) begin
				month_q <= 4'(CDO_LAST_MONTH);
			end else begin
				month_q <= start_month;
			end
			day_q    <= start_day;
			offset_q <= day_offset;
		end else begin
			if (red_en) begin
				if (rem_q >= red_amt) begin
					rem_q <= rem_q - red_amt;
				end
				step_q <= step_q + 3'd1;
			end
			if (d_load) begin
				d_q <= d_sum;
			end
			unique case (ystep)
				YS_NONE: begin
				end
				YS_INC: begin
					year_q <= year_q + YEAR_ONE_S;
					rem_q  <= {5'd0, rem_inc};
				end
				YS_DEC: begin
					year_q <= year_q - YEAR_ONE_S;
					rem_q  <= {5'd0, rem_dec};
				end
				YS_INC_QUAD: begin
					year_q <= year_q + QUAD_YEARS;
				end
				YS_DEC_QUAD: begin
					year_q <= year_q - QUAD_YEARS;
				end
				default: begin
				end
			endcase
			if (month_clear) begin
				month_q <= 4'd1;
			end else if (month_inc) begin
				month_q <= month_q + 4'd1;
			end
		end
	end

	// Result register: loaded in the cycle the walk ends and held until the next result.
	always_ff @(posedge clk) begin
		unique case (fin)
			FIN_NONE: begin
			end
			FIN_DATE: begin
				result_year  <= year_q[13:0];
				result_month <= month_q;
				result_day   <= d_q[4:0] + 5'd1;
				out_of_range <= 1'b0;
			end
			FIN_LOW: begin
				result_year  <= 14'd1;
				result_month <= 4'd1;
				result_day   <= 5'd1;
				out_of_range <= 1'b1;
			end
			FIN_HIGH: begin
				result_year  <= 14'(CDO_YEAR_MAX);
				result_month <= 4'(CDO_LAST_MONTH);
				result_day   <= 5'd31;
				out_of_range <= 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (fin != FIN_NONE);
		end
	end

	// A taken request keeps the block busy while it walks.
	`CDO_ASSERT_NEXT(a_accept_busy, accept, busy, "request taken but block not busy")
	// The result strobe comes only once the walk has returned to idle.
	`CDO_ASSERT_SAME(a_done_idle, done, !busy, "result strobe while still walking")
	// The month walk starts from a normalized, non-negative day count.
	`CDO_ASSERT_SAME(a_month_norm, state_q == ST_MONTH,
		!d_q[DW-1] && month_q >= 4'd1 && month_q <= 4'(CDO_LAST_MONTH),
		"month walk with bad day count or month")
	// A clamped result is one of the two range bounds.
	`CDO_ASSERT_SAME(a_clamp_vals, done && out_of_range,
		(result_year == 14'd1 && result_month == 4'd1 && result_day == 5'd1) ||
		(result_year == 14'(CDO_YEAR_MAX) && result_month == 4'(CDO_LAST_MONTH) &&
		result_day == 5'd31), "clamped result is not a range bound")
	// An in-range result is a plausible date.
	`CDO_ASSERT_SAME(a_date_ok, done && !out_of_range,
		result_year >= 14'd1 && result_year <= 14'(CDO_YEAR_MAX) && result_day != 5'd0 &&
		result_month >= 4'd1 && result_month <= 4'(CDO_LAST_MONTH), "result date out of range")

endmodule

/* hdl/cdo_day_unit.sv */
// Shared day-count adder of the date offset walk: one add per cycle with a chosen operand.
// Depends on cdo_pkg for the command struct and operation codes.
module cdo_day_unit
	import cdo_pkg::*;
#(
	parameter int OFFSET_BITS = CDO_OFFSET_BITS
) (
	input  cdo_cmd_t                 cmd,
	input  logic signed [((OFFSET_BITS > 18) ? OFFSET_BITS : 18) + 1:0] d_cur,
	input  logic [OFFSET_BITS-1:0]   offset,
	output logic signed [((OFFSET_BITS > 18) ? OFFSET_BITS : 18) + 1:0] d_next
);

	localparam int DW = ((OFFSET_BITS > 18) ? OFFSET_BITS : 18) + 2;
	localparam logic signed [DW-1:0] QUAD_D = DW'(CDO_QUAD_DAYS);

	logic signed [DW-1:0] op_a;
	logic signed [DW-1:0] op_b;

	always_comb begin
		op_a = d_cur;
		op_b = '0;
		unique case (cmd.op)
			OP_HOLD: begin
				op_b = '0;
			end
			OP_INIT: begin
				op_a = {{(DW-OFFSET_BITS){offset[OFFSET_BITS-1]}}, offset};
				op_b = {{(DW-10){cmd.base[9]}}, cmd.base};
			end
			OP_ADD_QUAD: begin
				op_b = QUAD_D;
			end
			OP_SUB_QUAD: begin
				op_b = -QUAD_D;
			end
			OP_ADD_YEAR: begin
				op_b = {{(DW-9){1'b0}}, cmd.ylen};
			end
			OP_SUB_YEAR: begin
				op_b = -{{(DW-9){1'b0}}, cmd.ylen};
			end
			OP_SUB_MONTH: begin
				op_b = -{{(DW-5){1'b0}}, cmd.mlen};
			end
			default: begin
				op_b = '0;
			end
		endcase
	end

	assign d_next = op_a + op_b;

endmodule

/* sim/tb_calendar_date_day_offset.sv */
`timescale 1ns / 100ps
// Self-checking testbench for calendar_date_day_offset: directed and random date offset requests.
// Depends on cdo_pkg and the calendar_date_day_offset RTL; holds its own calendar predictor.

module tb_calendar_date_day_offset;
	import cdo_pkg::*;

	localparam int OFS_W = CDO_OFFSET_BITS;

	// The predictor moves every year up by a multiple of 400 so that all day counts stay
	// positive. A shift by whole 400-year cycles leaves the leap pattern untouched.
	localparam longint EPOCH_SHIFT = 800;

	// Cycles without any accepted request or result before the run is declared hung. The
	// limit lies well past the slowest walk and the longest sender gap.
	localparam int STALL_LIMIT = 20000;

	// Settling time after the last result, well past the longest walk of the block.
	localparam int DRAIN_CYCLES = 1000;

	localparam int RANDOM_ITEMS = 750;

	typedef struct packed {
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic        flag;
	} date_result_t;

	logic                    clk;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic [13:0]             start_year;
	logic [3:0]              start_month;
	logic [4:0]              start_day;
	logic signed [OFS_W-1:0] day_offset;
	logic                    done;
	logic [13:0]             result_year;
	logic [3:0]              result_month;
	logic [4:0]              result_day;
	logic                    out_of_range;

	calendar_date_day_offset #(
		.OFFSET_BITS(OFS_W)
	) uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.start_year  (start_year),
		.start_month (start_month),
		.start_day   (start_day),
		.day_offset  (day_offset),
		.done        (done),
		.result_year (result_year),
		.result_month(result_month),
		.result_day  (result_day),
		.out_of_range(out_of_range)
	);

	// Gregorian leap rule on a year that may carry the epoch shift.
	function automatic bit leap_year(longint y);
		return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
	endfunction

	function automatic int month_days(longint y, int m);
		int len;
		case (m)
			2:             len = leap_year(y) ? 29 : 28;
			4, 6, 9, 11:   len = 30;
			default:       len = 31;
		endcase
		return len;
	endfunction

	// Day number of January 1st of year y, counted from January 1st of year 0.
	function automatic longint year_start_serial(longint y);
		return 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
	endfunction

	// Turns the start date into a day number, adds the offset and turns the sum back
	// into a date. A month code of 0 counts as January and one above 12 as December;
	// the day is counted from the first of the month, so day 0 and days past the end of
	// the month roll into the neighboring months. Results outside years 1..9999 clamp.
	function automatic date_result_t predict_offset_date(logic [13:0] y, logic [3:0] m,
			logic [4:0] d, logic signed [OFS_W-1:0] o);
		longint       yy;
		longint       serial;
		longint       ry;
		int           mm;
		int           rm;
		date_result_t r;
		yy = longint'(y) + EPOCH_SHIFT;
		mm = int'(m);
		if (mm < 1)
			mm = 1;
		if (mm > 12)
			mm = 12;
		serial = year_start_serial(yy);
		for (int i = 1; i < mm; i++)
			serial += month_days(yy, i);
		serial += longint'(d) - 1 + longint'(o);
		if (serial < 0)
			serial = 0;
		// Estimate the year from the mean year length, then correct it by single steps.
		ry = (serial * 400) / 146097;
		while (year_start_serial(ry + 1) <= serial)
			ry++;
		while (ry > 0 && year_start_serial(ry) > serial)
			ry--;
		serial -= year_start_serial(ry);
		rm = 1;
		while (rm < 12 && serial >= month_days(ry, rm)) begin
			serial -= month_days(ry, rm);
			rm++;
		end
		ry -= EPOCH_SHIFT;
		r.flag = 1'b0;
		if (ry < 1) begin
			ry = 1;
			rm = 1;
			serial = 0;
			r.flag = 1'b1;
		end else if (ry > 9999) begin
			ry = 9999;
			rm = 12;
			serial = 30;
			r.flag = 1'b1;
		end
		r.year  = 14'(ry);
		r.month = 4'(rm);
		r.day   = 5'(serial + 1);
		return r;
	endfunction

	// Keeps the predicted dates of accepted requests in order and checks each result
	// strobe against the oldest one.
	class date_scoreboard;
		date_result_t pending_dates[$];
		int unsigned  mismatches;

		function new();
			mismatches = 0;
		endfunction

		function void note_request(logic [13:0] y, logic [3:0] m, logic [4:0] d,
				logic signed [OFS_W-1:0] o);
			pending_dates.push_back(predict_offset_date(y, m, d, o));
		endfunction

		function void check_result(date_result_t got);
			date_result_t want;
			if (pending_dates.size() == 0) begin
				$error("result strobe with no request outstanding");
				mismatches++;
				return;
			end
			want = pending_dates.pop_front();
			if (got.year !== want.year) begin
				$error("result_year: expected %0d, actual %0d", want.year, got.year);
				mismatches++;
			end
			if (got.month !== want.month) begin
				$error("result_month: expected %0d, actual %0d", want.month, got.month);
				mismatches++;
			end
			if (got.day !== want.day) begin
				$error("result_day: expected %0d, actual %0d", want.day, got.day);
				mismatches++;
			end
			if (got.flag !== want.flag) begin
				$error("out_of_range: expected %0d, actual %0d", want.flag, got.flag);
				mismatches++;
			end
		endfunction

		function int outstanding();
			return pending_dates.size();
		endfunction
	endclass

	date_scoreboard sb;
	int             stall_cycles;
	int             no_gap_left;

	// Clock with a 10 ns period.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Results cannot be held off, so every strobe seen at a rising edge is checked.
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result({result_year, result_month, result_day, out_of_range});
	end

	// Watchdog: any accepted request or result restarts the count.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Idle cycles before the next request. Most gaps are zero or short and a few are long,
	// so the rise of start lands on every phase of the walk. Now and then a burst of
	// back-to-back requests follows.
	function automatic int pick_gap();
		int r;
		if (no_gap_left > 0) begin
			no_gap_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			no_gap_left = $urandom_range(20, 40);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 4);
		return $urandom_range(10, 80);
	endfunction

	// Called at a falling edge. Start stays high from one request to the next when there
	// is no gap, so it only ever gets one assignment per falling edge. The request is
	// taken at the first rising edge that sees busy low.
	task automatic send_request(logic [13:0] y, logic [3:0] m, logic [4:0] d,
			logic signed [OFS_W-1:0] o);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start_year  <= y;
		start_month <= m;
		start_day   <= d;
		day_offset  <= o;
		start       <= 1'b1;
		do
			@(posedge clk);
		while (busy);
		sb.note_request(y, m, d, o);
		@(negedge clk);
	endtask

	// Holds the sender off until every outstanding request has returned its result.
	task automatic drain_requests();
		start <= 1'b0;
		@(negedge clk);
		while (sb.outstanding() > 0)
			@(negedge clk);
	endtask

	function automatic logic signed [OFS_W-1:0] pick_offset();
		int r;
		int mag;
		r = $urandom_range(0, 99);
		if (r < 40) begin
			mag = $urandom_range(0, 800);
		end else if (r < 60) begin
			mag = $urandom_range(0, 4000);
		end else if (r < 90) begin
			return OFS_W'($urandom);
		end else begin
			case ($urandom_range(0, 4))
				0: return {1'b1, {(OFS_W-1){1'b0}}};
				1: return {1'b0, {(OFS_W-1){1'b1}}};
				2: return '0;
				3: return '1;
				default: return OFS_W'(1);
			endcase
		end
		return $urandom_range(0, 1) ? OFS_W'(-mag) : OFS_W'(mag);
	endfunction

	// Most random requests carry a valid date; the rest put any bits on every field.
	task automatic send_random_request();
		logic [13:0] y;
		logic [3:0]  m;
		logic [4:0]  d;
		int          r;
		r = $urandom_range(0, 99);
		if (r < 85) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: y = 14'($urandom_range(1, 9999));
				5, 6:          y = 14'($urandom_range(1, 200));
				7, 8:          y = 14'($urandom_range(9800, 9999));
				default:       y = 14'($urandom_range(1, 99) * 100 + $urandom_range(0, 2) - 1);
			endcase
			m = 4'($urandom_range(1, 12));
			d = 5'($urandom_range(1, month_days(longint'(y), int'(m))));
		end else begin
			y = 14'($urandom);
			m = 4'($urandom);
			d = 5'($urandom);
		end
		send_request(y, m, d, pick_offset());
	endtask

	initial begin
		sb           = new();
		no_gap_left  = 0;
		arst_n       = 1'b0;
		start        = 1'b0;
		start_year   = '0;
		start_month  = '0;
		start_day    = '0;
		day_offset   = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed requests: offset zero, both clamp directions and the dates just inside
		// them, leap and century years, month and day codes outside the calendar, and
		// start years outside 1..9999.
		send_request(14'd2024, 4'd1, 5'd1, OFS_W'(0));
		send_request(14'd1, 4'd1, 5'd1, {1'b1, {(OFS_W-1){1'b0}}});
		send_request(14'd1, 4'd1, 5'd1, OFS_W'(-1));
		send_request(14'd1, 4'd1, 5'd2, OFS_W'(-1));
		send_request(14'd9999, 4'd12, 5'd31, OFS_W'(1));
		send_request(14'd9999, 4'd12, 5'd31, {1'b0, {(OFS_W-1){1'b1}}});
		send_request(14'd9999, 4'd12, 5'd30, OFS_W'(1));
		send_request(14'd2000, 4'd2, 5'd28, OFS_W'(1));
		send_request(14'd1900, 4'd2, 5'd28, OFS_W'(1));
		send_request(14'd2400, 4'd3, 5'd1, OFS_W'(-1));
		send_request(14'd2023, 4'd3, 5'd1, OFS_W'(-1));
		send_request(14'd2024, 4'd0, 5'd15, OFS_W'(10));
		send_request(14'd2024, 4'd13, 5'd5, OFS_W'(30));
		send_request(14'd2024, 4'd15, 5'd31, OFS_W'(0));
		send_request(14'd2024, 4'd3, 5'd0, OFS_W'(0));
		send_request(14'd2023, 4'd2, 5'd31, OFS_W'(0));
		send_request(14'd2024, 4'd6, 5'd31, {1'b0, {(OFS_W-1){1'b1}}});
		send_request(14'd0, 4'd6, 5'd15, OFS_W'(0));
		send_request(14'd0, 4'd12, 5'd31, {1'b0, {(OFS_W-1){1'b1}}});
		send_request(14'd16383, 4'd1, 5'd1, {1'b1, {(OFS_W-1){1'b0}}});
		send_request(14'd10000, 4'd1, 5'd1, {1'b1, {(OFS_W-1){1'b0}}});
		send_request(14'd1, 4'd1, 5'd1, {1'b0, {(OFS_W-1){1'b1}}});
		send_request(14'd5000, 4'd7, 5'd4, {1'b1, {(OFS_W-1){1'b0}}});
		send_request(14'd1600, 4'd2, 5'd29, OFS_W'(-1461));

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			// Halfway through, the sender waits for the block to go fully quiet.
			if (n == RANDOM_ITEMS / 2)
				drain_requests();
			send_random_request();
		end
		start <= 1'b0;

		while (sb.outstanding() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
